@@ hw/rtl/gkc_pkg.sv @@
// Shared types and constants for the grey kernel convolution core.
package gkc_pkg;

  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned CfgDataBits = 60;
  localparam int unsigned SlotBits    = 12;
  localparam int unsigned GridSize    = 5;
  localparam int unsigned GridCentre  = 2;
  localparam int unsigned PixBits     = 8;
  localparam int unsigned PixMax      = 255;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_KROW0   = 3'd0,
    REG_KROW1   = 3'd1,
    REG_KROW2   = 3'd2,
    REG_KROW3   = 3'd3,
    REG_KROW4   = 3'd4,
    REG_WIDTH   = 3'd5,
    REG_HEIGHT  = 3'd6,
    REG_DIVISOR = 3'd7
  } cfg_idx_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_MAC,
    ST_DIV,
    ST_OUT
  } state_e;

endpackage

@@ hw/rtl/gkc_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
module gkc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ hw/rtl/gkc_divider.sv @@
// Restoring divider, one quotient bit per cycle, saturating at 255.
module gkc_divider #(
  parameter int unsigned NumBits = 40,
  parameter int unsigned DenBits = 20
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [NumBits-1:0] num_i,
  input  logic [DenBits-1:0] den_i,
  output logic               done_o,
  output logic [7:0]         quot_o
);

  localparam int unsigned CntBits = $clog2(NumBits + 1);

  logic [NumBits-1:0] num_q, num_d;
  logic [NumBits-1:0] quo_q, quo_d;
  logic [DenBits:0]   rem_q, rem_d;
  logic [DenBits-1:0] den_q, den_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic [DenBits:0]   trial;

  always_comb begin
    num_d  = num_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q[DenBits-1:0], num_q[NumBits-1]};
    if (start_i) begin
      num_d  = num_i;
      den_d  = den_i;
      rem_d  = '0;
      quo_d  = '0;
      cnt_d  = CntBits'(NumBits);
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[NumBits-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[NumBits-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[NumBits-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntBits'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = busy_q && (cnt_q == CntBits'(1));
  assign quot_o = (|quo_d[NumBits-1:8]) ? 8'(gkc_pkg::PixMax) : quo_d[7:0];

endmodule

@@ hw/rtl/grey_kernel_convolution_core.sv @@
// Top level of the 5x5 zero-padded grey convolution core.
// Sequence: an item that yields a result passes through a setup state, the tap loop and the
// divide before output valid rises.
// Flow: one item at a time; after a result is taken the sequencer returns to idle before the next
// transaction is accepted; items that yield none go back to back.
// Reset: asynchronous, active low; registers take their documented reset values,
// counters clear, the line store holds garbage until written.
module grey_kernel_convolution_core #(
  parameter int unsigned MAX_WIDTH = 1024,
  parameter int unsigned WINDOW    = 5,
  parameter int unsigned COEF_BITS = 12
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [gkc_pkg::CfgIdxBits-1:0]       cfg_idx_i,
  input  logic [gkc_pkg::CfgDataBits-1:0]      cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [7:0]                           pixel_value_i,
  input  logic                                 flush_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [7:0]                           filtered_value_o,
  output logic                                 frame_done_o
);

  localparam int unsigned HalfW     = WINDOW / 2;
  localparam int unsigned HistDepth = 2 * HalfW * MAX_WIDTH + 2 * HalfW + 1;
  localparam int unsigned AddrBits  = $clog2(HistDepth);
  localparam int unsigned ColBits   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned TapBits   = $clog2(WINDOW * WINDOW + 1);
  localparam int unsigned DyBits    = $clog2(WINDOW + 1);
  localparam int unsigned OffBits   = AddrBits + 1;
  localparam int unsigned SumBits   = 8 + COEF_BITS + 6;
  localparam int unsigned NumBits   = SumBits;

  // Configuration registers
  logic [gkc_pkg::CfgDataBits-1:0] krow_q [gkc_pkg::GridSize];
  logic [10:0] width_q;
  logic [15:0] height_q;
  logic [15:0] div_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < gkc_pkg::GridSize; i++) begin
        krow_q[i] <= '0;
      end
      krow_q[gkc_pkg::GridCentre] <= 60'd268435456;
      width_q  <= 11'd640;
      height_q <= 16'd480;
      div_q    <= 16'd1;
    end else if (cfg_we_i) begin
      case (gkc_pkg::cfg_idx_e'(cfg_idx_i))
        gkc_pkg::REG_KROW0:   krow_q[0] <= cfg_data_i;
        gkc_pkg::REG_KROW1:   krow_q[1] <= cfg_data_i;
        gkc_pkg::REG_KROW2:   krow_q[2] <= cfg_data_i;
        gkc_pkg::REG_KROW3:   krow_q[3] <= cfg_data_i;
        gkc_pkg::REG_KROW4:   krow_q[4] <= cfg_data_i;
        gkc_pkg::REG_WIDTH:   width_q   <= cfg_data_i[10:0];
        gkc_pkg::REG_HEIGHT:  height_q  <= cfg_data_i[15:0];
        gkc_pkg::REG_DIVISOR: div_q     <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Effective geometry: zero taken as one, width saturates.
  logic [ColBits-1:0] w_eff;
  logic [15:0]        h_eff;
  logic [15:0]        d_eff;
  always_comb begin
    if (width_q == '0) begin
      w_eff = ColBits'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      w_eff = ColBits'(MAX_WIDTH);
    end else begin
      w_eff = ColBits'(width_q);
    end
    h_eff = (height_q == '0) ? 16'd1 : height_q;
    d_eff = (div_q == '0) ? 16'd1 : div_q;
  end

  // Sequencer and counters
  gkc_pkg::state_e state_q, state_d;
  logic [AddrBits-1:0] wpos_q, wpos_d;
  logic [ColBits-1:0]  in_col_q, in_col_d, out_col_q, out_col_d;
  logic [16:0]         in_row_q, in_row_d, out_row_q, out_row_d;
  logic [OffBits-1:0]  fill_q, fill_d;
  logic [DyBits-1:0]   ty_q, ty_d, tx_q, tx_d;
  logic [TapBits-1:0]  rd_cnt_q, rd_cnt_d;
  logic                mac_vld_q, mac_vld_d;
  logic [DyBits-1:0]   my_q, my_d, mx_q, mx_d;
  logic signed [SumBits-1:0] sum_q, sum_d;
  logic                div_start;
  logic                div_done;
  logic [7:0]          div_quot;
  logic                done_flag_q, done_flag_d;
  logic [7:0]          res_q, res_d;
  logic                in_frame;
  logic                in_fire, out_fire;
  logic                ram_we;
  logic [7:0]          ram_wdata;
  logic [AddrBits-1:0] ram_raddr;
  logic [7:0]          ram_rdata;
  logic [OffBits-1:0]  lag;
  logic [OffBits-1:0]  off;
  logic [OffBits:0]    raddr_sum;
  logic signed [17:0]  tap_r, tap_c;
  logic                tap_in;
  logic [COEF_BITS-1:0] coef_raw;
  logic signed [COEF_BITS-1:0] coef;
  logic signed [COEF_BITS+8:0] prod;

  assign in_frame  = in_row_q < {1'b0, h_eff};
  assign in_stall_o = (state_q != gkc_pkg::ST_IDLE);
  assign in_fire   = in_valid_i && !in_stall_o;
  assign out_valid_o = (state_q == gkc_pkg::ST_OUT);
  assign out_fire  = out_valid_o && !out_stall_i;
  assign lag       = OffBits'(HalfW * w_eff + HalfW);

  // Tap geometry for the tap being addressed (ty, tx are 0..WINDOW-1 -> dy = ty-HalfW).
  // The newest entry is the tap two rows and two pixels ahead of the output pixel.
  always_comb begin
    off = OffBits'((2 * HalfW - ty_q) * w_eff) + OffBits'(2 * HalfW - tx_q);
    raddr_sum = {1'b0, wpos_q} + (OffBits+1)'(HistDepth) - {1'b0, off};
    ram_raddr = (raddr_sum >= (OffBits+1)'(HistDepth))
                ? AddrBits'(raddr_sum - (OffBits+1)'(HistDepth))
                : AddrBits'(raddr_sum);
  end

  // Window bounds and coefficient for the tap whose data arrives now.
  always_comb begin
    tap_r  = $signed({1'b0, out_row_q}) + $signed(18'(my_q)) - $signed(18'(HalfW));
    tap_c  = $signed(18'(out_col_q)) + $signed(18'(mx_q)) - $signed(18'(HalfW));
    tap_in = (tap_r >= 0) && (tap_r < $signed(18'(h_eff)))
          && (tap_c >= 0) && (tap_c < $signed(18'(w_eff)));
    coef_raw = krow_q[gkc_pkg::GridCentre + HalfW - my_q]
                     [(gkc_pkg::GridCentre + HalfW - mx_q) * gkc_pkg::SlotBits +: COEF_BITS];
    coef = $signed(coef_raw);
    prod = $signed({1'b0, ram_rdata}) * coef;
  end

  always_comb begin
    state_d    = state_q;
    wpos_d     = wpos_q;
    in_col_d   = in_col_q;
    in_row_d   = in_row_q;
    out_col_d  = out_col_q;
    out_row_d  = out_row_q;
    fill_d     = fill_q;
    ty_d       = ty_q;
    tx_d       = tx_q;
    rd_cnt_d   = rd_cnt_q;
    mac_vld_d  = 1'b0;
    my_d       = ty_q;
    mx_d       = tx_q;
    sum_d      = sum_q;
    done_flag_d = done_flag_q;
    res_d      = res_q;
    ram_we     = 1'b0;
    ram_wdata  = pixel_value_i;
    div_start  = 1'b0;
    case (state_q)
      gkc_pkg::ST_IDLE: begin
        if (in_fire && !(flush_i && in_frame)) begin
          ram_we    = 1'b1;
          ram_wdata = in_frame ? pixel_value_i : 8'd0;
          wpos_d    = (32'(wpos_q) == HistDepth - 1) ? '0 : wpos_q + 1'b1;
          if (in_col_q + 1'b1 >= w_eff) begin
            in_col_d = '0;
            in_row_d = in_row_q + 1'b1;
          end else begin
            in_col_d = in_col_q + 1'b1;
          end
          if (fill_q < lag) begin
            fill_d = fill_q + 1'b1;
          end else begin
            state_d  = gkc_pkg::ST_SHIFT;
          end
        end
      end
      gkc_pkg::ST_SHIFT: begin
        // Lets the new write land before taps are read.
        ty_d     = '0;
        tx_d     = '0;
        rd_cnt_d = '0;
        sum_d    = '0;
        state_d  = gkc_pkg::ST_MAC;
      end
      gkc_pkg::ST_MAC: begin
        if (32'(rd_cnt_q) < WINDOW * WINDOW) begin
          mac_vld_d = 1'b1;
          rd_cnt_d  = rd_cnt_q + 1'b1;
          if (32'(tx_q) == WINDOW - 1) begin
            tx_d = '0;
            ty_d = ty_q + 1'b1;
          end else begin
            tx_d = tx_q + 1'b1;
          end
        end
        if (mac_vld_q && tap_in) begin
          sum_d = sum_q + SumBits'(prod);
        end
        if (32'(rd_cnt_q) == WINDOW * WINDOW && !mac_vld_q) begin
          state_d   = gkc_pkg::ST_DIV;
          div_start = 1'b1;
        end
      end
      gkc_pkg::ST_DIV: begin
        if (div_done) begin
          res_d       = (sum_q <= 0) ? 8'd0 : div_quot;
          done_flag_d = (out_col_q + 1'b1 >= w_eff) && (out_row_q + 1'b1 >= {1'b0, h_eff});
          state_d     = gkc_pkg::ST_OUT;
        end
      end
      gkc_pkg::ST_OUT: begin
        if (out_fire) begin
          state_d = gkc_pkg::ST_IDLE;
          if (done_flag_q) begin
            in_col_d  = '0;
            in_row_d  = '0;
            out_col_d = '0;
            out_row_d = '0;
            fill_d    = '0;
          end else if (out_col_q + 1'b1 >= w_eff) begin
            out_col_d = '0;
            out_row_d = out_row_q + 1'b1;
          end else begin
            out_col_d = out_col_q + 1'b1;
          end
        end
      end
      default: state_d = gkc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= gkc_pkg::ST_IDLE;
      wpos_q     <= '0;
      in_col_q   <= '0;
      in_row_q   <= '0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      fill_q     <= '0;
      ty_q       <= '0;
      tx_q       <= '0;
      rd_cnt_q   <= '0;
      mac_vld_q  <= 1'b0;
      done_flag_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      wpos_q     <= wpos_d;
      in_col_q   <= in_col_d;
      in_row_q   <= in_row_d;
      out_col_q  <= out_col_d;
      out_row_q  <= out_row_d;
      fill_q     <= fill_d;
      ty_q       <= ty_d;
      tx_q       <= tx_d;
      rd_cnt_q   <= rd_cnt_d;
      mac_vld_q  <= mac_vld_d;
      done_flag_q <= done_flag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    my_q     <= my_d;
    mx_q     <= mx_d;
    sum_q    <= sum_d;
    res_q    <= res_d;
  end

  // History of absorbed items; window taps are read back at computed offsets.
  gkc_ram #(
    .Width (8),
    .Depth (HistDepth)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wpos_d),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Division by 16*divisor, floored.
  gkc_divider #(
    .NumBits (NumBits),
    .DenBits (20)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (NumBits'(sum_q)),
    .den_i   ({d_eff, 4'b0000}),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign filtered_value_o = res_q;
  assign frame_done_o     = done_flag_q;

  // Input is never taken while a result waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_valid_o |-> in_stall_o)
    else $error("input taken while result pending");
  // A stalled result keeps its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(filtered_value_o))
    else $error("result changed under stall");
  // Divider completes only while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == gkc_pkg::ST_DIV)
    else $error("stray divider completion");

endmodule
